// File: rtl/trs_point_transform_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the point transform block
// Shared property forms; every use is clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef TRS_POINT_TRANSFORM_DEFINES_SVH
`define TRS_POINT_TRANSFORM_DEFINES_SVH

// same-cycle implication
`define TRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/trs_pkg.sv
// ---------------------------------------------------------------------------
// trs_pkg
// Widths, register codes and the transform register set of the point
// transform pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trs_pkg;

    localparam int CW     = 32;   // coordinate, Q16.16
    localparam int QW     = 16;   // quaternion part, Q1.14; also Q8.8 scale
    localparam int PW     = 48;   // coordinate times scale
    localparam int SW     = 40;   // scaled coordinate
    localparam int MW1    = 56;   // quat part times scaled coordinate
    localparam int TW     = 43;   // t = 2 * round(u x s)
    localparam int MW2    = 59;   // quat part times t
    localparam int AW     = 45;   // rounded rotation terms
    localparam int RW     = 47;   // sum before clamp
    localparam int NSTG   = 9;    // pipeline register stages
    localparam int IDXW   = 3;
    localparam int CFGW   = 48;

    // cross product operand order: c[i] = u[NXT]*v[PRV] - u[PRV]*v[NXT]
    localparam int unsigned NXT [3] = '{1, 2, 0};
    localparam int unsigned PRV [3] = '{2, 0, 1};

    localparam logic [QW-1:0] QUAT_W_RST = 16'h4000;   // 1.0
    localparam logic [QW-1:0] SCALE_ONE  = 16'h0100;   // 1.0

    typedef enum logic [IDXW-1:0] {
        REG_QUAT_W   = 3'd0,
        REG_QUAT_X   = 3'd1,
        REG_QUAT_Y   = 3'd2,
        REG_QUAT_Z   = 3'd3,
        REG_SCALE    = 3'd4,
        REG_OFFSET_X = 3'd5,
        REG_OFFSET_Y = 3'd6,
        REG_OFFSET_Z = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [QW-1:0]        qw;
        logic [2:0][QW-1:0]   qu;     // x, y, z at 0, 1, 2
        logic [2:0][QW-1:0]   sc;
        logic [2:0][CW-1:0]   off;
    } t_xform;

endpackage

// File: rtl/trs_cfg.sv
// ---------------------------------------------------------------------------
// trs_cfg
// Transform register set, written through the configuration channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [trs_pkg::IDXW-1:0]    i_cfg_index,
    input  logic [trs_pkg::CFGW-1:0]    i_cfg_data,
    output trs_pkg::t_xform             o_xform
);

    trs_pkg::t_xform r_xform;
    trs_pkg::t_xform n_xform;

    always_comb begin
        n_xform = r_xform;
        if (i_cfg_valid) begin
            unique case (trs_pkg::t_reg_idx'(i_cfg_index))
                trs_pkg::REG_QUAT_W:   n_xform.qw     = i_cfg_data[trs_pkg::QW-1:0];
                trs_pkg::REG_QUAT_X:   n_xform.qu[0]  = i_cfg_data[trs_pkg::QW-1:0];
                trs_pkg::REG_QUAT_Y:   n_xform.qu[1]  = i_cfg_data[trs_pkg::QW-1:0];
                trs_pkg::REG_QUAT_Z:   n_xform.qu[2]  = i_cfg_data[trs_pkg::QW-1:0];
                trs_pkg::REG_SCALE:    n_xform.sc     = i_cfg_data;
                trs_pkg::REG_OFFSET_X: n_xform.off[0] = i_cfg_data[trs_pkg::CW-1:0];
                trs_pkg::REG_OFFSET_Y: n_xform.off[1] = i_cfg_data[trs_pkg::CW-1:0];
                trs_pkg::REG_OFFSET_Z: n_xform.off[2] = i_cfg_data[trs_pkg::CW-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xform.qw  <= trs_pkg::QUAT_W_RST;
            r_xform.qu  <= '0;
            r_xform.sc  <= {3{trs_pkg::SCALE_ONE}};
            r_xform.off <= '0;
        end else begin
            r_xform <= n_xform;
        end
    end

    assign o_xform = r_xform;

endmodule

// File: rtl/trs_scale.sv
// ---------------------------------------------------------------------------
// trs_scale
// Stages 0-2: input register, per-axis scale multiply, round to Q16.16.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_scale (
    input  logic                                i_clk,
    input  logic [2:0]                          i_ce,
    input  logic                                i_typ,
    input  logic [2:0][trs_pkg::CW-1:0]         i_vec,
    input  logic [2:0][trs_pkg::QW-1:0]         i_sc,
    output logic                                o_typ,
    output logic [2:0][trs_pkg::SW-1:0]         o_s
);

    localparam int PW = trs_pkg::PW;
    localparam int SW = trs_pkg::SW;

    logic                        r0_typ;
    logic [2:0][trs_pkg::CW-1:0] r0_vec;
    logic                        r1_typ;
    logic signed [PW-1:0]        r1_p [3];
    logic signed [PW-1:0]        n1_p [3];
    logic                        r2_typ;
    logic [2:0][SW-1:0]          r2_s;
    logic [2:0][SW-1:0]          n2_s;
    logic [PW:0]                 w_rs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_p[i] = $signed(r0_vec[i]) * $signed(i_sc[i]);
            // round half up, drop 8 fraction bits
            w_rs[i] = {r1_p[i][PW-1], r1_p[i]} + (PW+1)'(128);
            n2_s[i] = w_rs[i][SW+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r0_typ <= i_typ;
            r0_vec <= i_vec;
        end
        if (i_ce[1]) begin
            r1_typ <= r0_typ;
            r1_p   <= n1_p;
        end
        if (i_ce[2]) begin
            r2_typ <= r1_typ;
            r2_s   <= n2_s;
        end
    end

    assign o_typ = r2_typ;
    assign o_s   = r2_s;

endmodule

// File: rtl/trs_rotate.sv
// ---------------------------------------------------------------------------
// trs_rotate
// Stages 3-6: quaternion rotation terms. t = 2 round(u x s), then
// a = round(w t) and b = round(u x t), each product registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_rotate (
    input  logic                                i_clk,
    input  logic [3:0]                          i_ce,
    input  logic                                i_typ,
    input  logic [2:0][trs_pkg::SW-1:0]         i_s,
    input  logic [trs_pkg::QW-1:0]              i_qw,
    input  logic [2:0][trs_pkg::QW-1:0]         i_qu,
    output logic                                o_typ,
    output logic [2:0][trs_pkg::SW-1:0]         o_s,
    output logic [2:0][trs_pkg::AW-1:0]         o_a,
    output logic [2:0][trs_pkg::AW-1:0]         o_b
);

    localparam int SW  = trs_pkg::SW;
    localparam int MW1 = trs_pkg::MW1;
    localparam int TW  = trs_pkg::TW;
    localparam int MW2 = trs_pkg::MW2;
    localparam int AW  = trs_pkg::AW;

    // stage 3
    logic                   r3_typ;
    logic [2:0][SW-1:0]     r3_s;
    logic signed [MW1-1:0]  r3_ma [3];
    logic signed [MW1-1:0]  r3_mb [3];
    logic signed [MW1-1:0]  n3_ma [3];
    logic signed [MW1-1:0]  n3_mb [3];
    // stage 4
    logic                   r4_typ;
    logic [2:0][SW-1:0]     r4_s;
    logic [2:0][TW-1:0]     r4_t;
    logic [2:0][TW-1:0]     n4_t;
    logic [MW1:0]           w_cd [3];
    logic [MW1+1:0]         w_cr [3];
    // stage 5
    logic                   r5_typ;
    logic [2:0][SW-1:0]     r5_s;
    logic signed [MW2-1:0]  r5_wt [3];
    logic signed [MW2-1:0]  r5_ua [3];
    logic signed [MW2-1:0]  r5_ub [3];
    logic signed [MW2-1:0]  n5_wt [3];
    logic signed [MW2-1:0]  n5_ua [3];
    logic signed [MW2-1:0]  n5_ub [3];
    // stage 6
    logic                   r6_typ;
    logic [2:0][SW-1:0]     r6_s;
    logic [2:0][AW-1:0]     r6_a;
    logic [2:0][AW-1:0]     r6_b;
    logic [2:0][AW-1:0]     n6_a;
    logic [2:0][AW-1:0]     n6_b;
    logic [MW2:0]           w_ra [3];
    logic [MW2:0]           w_bd [3];
    logic [MW2+1:0]         w_rb [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_ma[i] = $signed(i_qu[trs_pkg::NXT[i]]) * $signed(i_s[trs_pkg::PRV[i]]);
            n3_mb[i] = $signed(i_qu[trs_pkg::PRV[i]]) * $signed(i_s[trs_pkg::NXT[i]]);

            w_cd[i] = {r3_ma[i][MW1-1], r3_ma[i]} - {r3_mb[i][MW1-1], r3_mb[i]};
            w_cr[i] = {w_cd[i][MW1], w_cd[i]} + (MW1+2)'(8192);
            n4_t[i] = {w_cr[i][TW+12:14], 1'b0};

            n5_wt[i] = $signed(i_qw) * $signed(r4_t[i]);
            n5_ua[i] = $signed(i_qu[trs_pkg::NXT[i]]) * $signed(r4_t[trs_pkg::PRV[i]]);
            n5_ub[i] = $signed(i_qu[trs_pkg::PRV[i]]) * $signed(r4_t[trs_pkg::NXT[i]]);

            w_ra[i] = {r5_wt[i][MW2-1], r5_wt[i]} + (MW2+1)'(8192);
            n6_a[i] = w_ra[i][AW+13:14];
            w_bd[i] = {r5_ua[i][MW2-1], r5_ua[i]} - {r5_ub[i][MW2-1], r5_ub[i]};
            w_rb[i] = {w_bd[i][MW2], w_bd[i]} + (MW2+2)'(8192);
            n6_b[i] = w_rb[i][AW+13:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r3_typ <= i_typ;
            r3_s   <= i_s;
            r3_ma  <= n3_ma;
            r3_mb  <= n3_mb;
        end
        if (i_ce[1]) begin
            r4_typ <= r3_typ;
            r4_s   <= r3_s;
            r4_t   <= n4_t;
        end
        if (i_ce[2]) begin
            r5_typ <= r4_typ;
            r5_s   <= r4_s;
            r5_wt  <= n5_wt;
            r5_ua  <= n5_ua;
            r5_ub  <= n5_ub;
        end
        if (i_ce[3]) begin
            r6_typ <= r5_typ;
            r6_s   <= r5_s;
            r6_a   <= n6_a;
            r6_b   <= n6_b;
        end
    end

    assign o_typ = r6_typ;
    assign o_s   = r6_s;
    assign o_a   = r6_a;
    assign o_b   = r6_b;

endmodule

// File: rtl/trs_sat.sv
// ---------------------------------------------------------------------------
// trs_sat
// Stages 7-8: final sum with optional translation, clamp to 32 bits.
// Stage 8 is the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_sat (
    input  logic                                i_clk,
    input  logic [1:0]                          i_ce,
    input  logic                                i_typ,
    input  logic [2:0][trs_pkg::SW-1:0]         i_s,
    input  logic [2:0][trs_pkg::AW-1:0]         i_a,
    input  logic [2:0][trs_pkg::AW-1:0]         i_b,
    input  logic [2:0][trs_pkg::CW-1:0]         i_off,
    output logic [2:0][trs_pkg::CW-1:0]         o_vec,
    output logic                                o_sat
);

    localparam int CW = trs_pkg::CW;
    localparam int SW = trs_pkg::SW;
    localparam int AW = trs_pkg::AW;
    localparam int RW = trs_pkg::RW;

    logic [2:0][RW-1:0] r7_r;
    logic [2:0][RW-1:0] n7_r;
    logic [2:0][CW-1:0] r8_vec;
    logic [2:0][CW-1:0] n8_vec;
    logic               r8_sat;
    logic               n8_sat;
    logic [RW-1:0]      w_off [3];
    logic [2:0]         w_hi;
    logic [2:0]         w_lo;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_off[i] = i_typ ? {{(RW-CW){i_off[i][CW-1]}}, i_off[i]} : '0;
            n7_r[i]  = {{(RW-SW){i_s[i][SW-1]}}, i_s[i]}
                     + {{(RW-AW){i_a[i][AW-1]}}, i_a[i]}
                     + {{(RW-AW){i_b[i][AW-1]}}, i_b[i]}
                     + w_off[i];
            // out of range when the bits above the sign are not all equal to it
            w_hi[i] = !r7_r[i][RW-1] && (|r7_r[i][RW-2:CW-1]);
            w_lo[i] =  r7_r[i][RW-1] && !(&r7_r[i][RW-2:CW-1]);
            priority if (w_hi[i]) begin
                n8_vec[i] = {1'b0, {(CW-1){1'b1}}};
            end else if (w_lo[i]) begin
                n8_vec[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n8_vec[i] = r7_r[i][CW-1:0];
            end
        end
        n8_sat = |(w_hi | w_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_ce[0]) begin
            r7_r <= n7_r;
        end
        if (i_ce[1]) begin
            r8_vec <= n8_vec;
            r8_sat <= n8_sat;
        end
    end

    assign o_vec = r8_vec;
    assign o_sat = r8_sat;

endmodule

// File: rtl/trs_point_transform.sv
// ---------------------------------------------------------------------------
// trs_point_transform
// Scale, quaternion rotate and optionally translate one 3D item per beat.
// ---------------------------------------------------------------------------
// Takes one beat per clock unless a stall backs up to the input, and gives
// one result beat per input beat, in order. o_m_tvalid rises once the
// accepted beat has passed the nine register stages (the first one
// captures the beat): input, scale multiply, round, u x s products, t,
// w*t and u x t products, rounding, final sum, clamp/output register.
// Bubbles are squeezed out on stall, so the input keeps accepting while a
// result waits until all nine stages are full. Configuration registers are
// read directly by the pipeline: write them only while no beat is in flight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trs_point_transform_defines.svh"

module trs_point_transform (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [95:0]                 i_s_tdata,  // in_x, in_y, in_z
    input  logic                        i_s_tuser,  // req_type
    // output stream
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [95:0]                 o_m_tdata,  // out_x, out_y, out_z
    output logic                        o_m_tuser,  // saturated
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [trs_pkg::IDXW-1:0]    i_cfg_index,
    input  logic [trs_pkg::CFGW-1:0]    i_cfg_data
);

    localparam int NSTG = trs_pkg::NSTG;

    trs_pkg::t_xform                w_xform;
    logic [NSTG-1:0]                r_v;
    logic [NSTG-1:0]                n_v;
    logic [NSTG-1:0]                w_ce;
    logic [2:0][trs_pkg::CW-1:0]    w_in_vec;
    logic                           w_typ2;
    logic [2:0][trs_pkg::SW-1:0]    w_s2;
    logic                           w_typ6;
    logic [2:0][trs_pkg::SW-1:0]    w_s6;
    logic [2:0][trs_pkg::AW-1:0]    w_a6;
    logic [2:0][trs_pkg::AW-1:0]    w_b6;
    logic [2:0][trs_pkg::CW-1:0]    w_out_vec;

    assign o_cfg_ready = 1'b1;
    assign w_in_vec    = i_s_tdata;

    // a stage advances when it is empty or the next one advances
    always_comb begin
        w_ce[NSTG-1] = !r_v[NSTG-1] || i_m_tready;
        for (int k = NSTG-2; k >= 0; k--) begin
            w_ce[k] = !r_v[k] || w_ce[k+1];
        end
        n_v = r_v;
        if (w_ce[0]) begin
            n_v[0] = i_s_tvalid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_ce[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_s_tready = w_ce[0];
    assign o_m_tvalid = r_v[NSTG-1];
    assign o_m_tdata  = w_out_vec;

    trs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_xform     (w_xform)
    );

    trs_scale u_scale (
        .i_clk (i_clk),
        .i_ce  (w_ce[2:0]),
        .i_typ (i_s_tuser),
        .i_vec (w_in_vec),
        .i_sc  (w_xform.sc),
        .o_typ (w_typ2),
        .o_s   (w_s2)
    );

    trs_rotate u_rotate (
        .i_clk (i_clk),
        .i_ce  (w_ce[6:3]),
        .i_typ (w_typ2),
        .i_s   (w_s2),
        .i_qw  (w_xform.qw),
        .i_qu  (w_xform.qu),
        .o_typ (w_typ6),
        .o_s   (w_s6),
        .o_a   (w_a6),
        .o_b   (w_b6)
    );

    trs_sat u_sat (
        .i_clk (i_clk),
        .i_ce  (w_ce[8:7]),
        .i_typ (w_typ6),
        .i_s   (w_s6),
        .i_a   (w_a6),
        .i_b   (w_b6),
        .i_off (w_xform.off),
        .o_vec (w_out_vec),
        .o_sat (o_m_tuser)
    );

    `TRS_ASSERT_NXT(a_accept_fills_s0, i_s_tvalid && o_s_tready, r_v[0],
        "accepted beat did not reach stage 0")
    `TRS_ASSERT_IMP(a_block_only_full, !o_s_tready, &r_v,
        "input blocked with a bubble in the pipeline")
    `TRS_ASSERT_NXT(a_s4_holds, r_v[4] && !w_ce[4], r_v[4],
        "stalled stage 4 lost its beat")
    `TRS_ASSERT_IMP(a_sat_clamped, o_m_tvalid && o_m_tuser,
        o_m_tdata[31:0] == 32'h7fffffff || o_m_tdata[31:0] == 32'h80000000 ||
        o_m_tdata[63:32] == 32'h7fffffff || o_m_tdata[63:32] == 32'h80000000 ||
        o_m_tdata[95:64] == 32'h7fffffff || o_m_tdata[95:64] == 32'h80000000,
        "saturated flag without a clamped component")

endmodule

// File: tb/tb_trs_point_transform.sv
// ---------------------------------------------------------------------------
// tb_trs_point_transform
// Self-checking bench for the scale / rotate / translate pipeline.
// ---------------------------------------------------------------------------
// Loads transforms over the config channel while the pipe is empty, streams
// points and directions with random gaps on both sides, and compares every
// output beat with a fixed-point prediction done in 64-bit integers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trs_point_transform;

    localparam int     CW           = trs_pkg::CW;
    localparam int     IDXW         = trs_pkg::IDXW;
    localparam int     CFGW         = trs_pkg::CFGW;
    localparam int     NSTG         = trs_pkg::NSTG;
    localparam longint COORD_MAX    = 64'sd2147483647;
    localparam longint COORD_MIN    = -64'sd2147483648;
    localparam int     CHOKE_CYCLES = 80;
    localparam int     PHASE_ITEMS  = 236;
    localparam bit     KIND_DIR     = 1'b0;
    localparam bit     KIND_POINT   = 1'b1;

    typedef struct {
        logic [CW-1:0] c [3];
        logic          sat;
    } xf_result_t;

    // expected outputs of accepted beats, kept in arrival order
    class xform_checker;
        longint     qw;
        longint     qu [3];
        longint     sc [3];
        longint     off [3];
        xf_result_t pending [$];
        int         errors;

        function new();
            qw = 16384;
            for (int i = 0; i < 3; i++) begin
                qu[i]  = 0;
                sc[i]  = 256;
                off[i] = 0;
            end
            errors = 0;
        endfunction

        function void set_reg(trs_pkg::t_reg_idx idx, logic [CFGW-1:0] d);
            case (idx)
                trs_pkg::REG_QUAT_W:   qw     = longint'(signed'(d[15:0]));
                trs_pkg::REG_QUAT_X:   qu[0]  = longint'(signed'(d[15:0]));
                trs_pkg::REG_QUAT_Y:   qu[1]  = longint'(signed'(d[15:0]));
                trs_pkg::REG_QUAT_Z:   qu[2]  = longint'(signed'(d[15:0]));
                trs_pkg::REG_SCALE: begin
                    sc[0] = longint'(signed'(d[15:0]));
                    sc[1] = longint'(signed'(d[31:16]));
                    sc[2] = longint'(signed'(d[47:32]));
                end
                trs_pkg::REG_OFFSET_X: off[0] = longint'(signed'(d[31:0]));
                trs_pkg::REG_OFFSET_Y: off[1] = longint'(signed'(d[31:0]));
                trs_pkg::REG_OFFSET_Z: off[2] = longint'(signed'(d[31:0]));
                default: ;
            endcase
        endfunction

        // round to nearest, ties toward +inf
        static function longint rnd_shift(longint v, int n);
            return (v + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function void note_point(logic kind, logic [3*CW-1:0] d);
            longint     s [3];
            longint     t [3];
            longint     r;
            int         nx;
            int         pv;
            xf_result_t e;
            e.sat = 1'b0;
            for (int i = 0; i < 3; i++)
                s[i] = rnd_shift(longint'(signed'(d[CW*i +: CW])) * sc[i], 8);
            for (int i = 0; i < 3; i++) begin
                nx   = (i + 1) % 3;
                pv   = (i + 2) % 3;
                t[i] = 2 * rnd_shift(qu[nx] * s[pv] - qu[pv] * s[nx], 14);
            end
            for (int i = 0; i < 3; i++) begin
                nx = (i + 1) % 3;
                pv = (i + 2) % 3;
                r  = s[i] + rnd_shift(qw * t[i], 14)
                   + rnd_shift(qu[nx] * t[pv] - qu[pv] * t[nx], 14);
                if (kind == KIND_POINT)
                    r += off[i];
                if (r > COORD_MAX) begin
                    r     = COORD_MAX;
                    e.sat = 1'b1;
                end else if (r < COORD_MIN) begin
                    r     = COORD_MIN;
                    e.sat = 1'b1;
                end
                e.c[i] = r[CW-1:0];
            end
            pending.push_back(e);
        endfunction

        function void check_point(logic [3*CW-1:0] d, logic sat);
            xf_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected output beat %h sat %b", $time, d, sat);
                errors++;
                return;
            end
            e = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (d[CW*i +: CW] !== e.c[i]) begin
                    $display("%0t: coord %0d mismatch: expected %h actual %h",
                             $time, i, e.c[i], d[CW*i +: CW]);
                    errors++;
                end
            end
            if (sat !== e.sat) begin
                $display("%0t: saturated mismatch: expected %b actual %b",
                         $time, e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic [3*CW-1:0]   s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tready  = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [IDXW-1:0]   cfg_index = '0;
    logic [CFGW-1:0]   cfg_data  = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic [3*CW-1:0]   m_tdata;
    logic              m_tuser;
    logic              cfg_ready;

    bit                steady    = 1'b0;
    bit                choke_req = 1'b0;
    xform_checker      sb;

    trs_point_transform u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return $urandom();
            5, 6, 7: return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
            8:       return '0;
            default: return '1;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_reg(trs_pkg::t_reg_idx'(cfg_index), cfg_data);
        if (rst_n && s_tvalid && s_tready)
            sb.note_point(s_tuser, s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_point(m_tdata, m_tuser);
    end

    // output side: random stalls, or one long hold-off on request
    initial begin
        int gap;
        forever begin
            if (choke_req) begin
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge i_clk);
                choke_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                m_tready <= 1'b1;
                repeat (steady ? 1 : $urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // leaves tvalid high so a following beat can go out back to back
    task automatic send_point(input logic kind, input logic [CW-1:0] x,
                              input logic [CW-1:0] y, input logic [CW-1:0] z);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        s_tuser  <= kind;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic write_reg(input trs_pkg::t_reg_idx idx, input logic [CFGW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // upper garbage bits check that narrow registers ignore them
    task automatic load_xform(input logic [15:0] qw, input logic [15:0] qx,
                              input logic [15:0] qy, input logic [15:0] qz,
                              input logic [47:0] scale, input logic [31:0] ox,
                              input logic [31:0] oy, input logic [31:0] oz);
        write_reg(trs_pkg::REG_QUAT_W,   {$urandom(), qw});
        write_reg(trs_pkg::REG_QUAT_X,   {$urandom(), qx});
        write_reg(trs_pkg::REG_QUAT_Y,   {$urandom(), qy});
        write_reg(trs_pkg::REG_QUAT_Z,   {$urandom(), qz});
        write_reg(trs_pkg::REG_SCALE,    scale);
        write_reg(trs_pkg::REG_OFFSET_X, {16'($urandom()), ox});
        write_reg(trs_pkg::REG_OFFSET_Y, {16'($urandom()), oy});
        write_reg(trs_pkg::REG_OFFSET_Z, {16'($urandom()), oz});
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_xform(input int mode);
        real         a [4];
        real         mag;
        logic [15:0] q [4];
        logic [15:0] s [3];
        logic [31:0] o [3];
        mag = 0.0;
        for (int i = 0; i < 4; i++) begin
            a[i] = real'($urandom_range(0, 2000)) - 1000.0;
            mag += a[i] * a[i];
        end
        mag = (mag < 1.0) ? 1.0 : $sqrt(mag);
        for (int i = 0; i < 4; i++) begin
            case (mode)
                1:       q[i] = 16'($urandom());
                2: begin
                    case ($urandom_range(0, 4))
                        0:       q[i] = 16'h8000;
                        1:       q[i] = 16'h7fff;
                        2:       q[i] = 16'h4000;
                        3:       q[i] = 16'hc000;
                        default: q[i] = 16'h0000;
                    endcase
                end
                default: q[i] = 16'($rtoi(a[i] * 16384.0 / mag));
            endcase
        end
        for (int i = 0; i < 3; i++) begin
            if (mode == 1 || mode == 2)
                s[i] = 16'($urandom());
            else
                s[i] = 16'($urandom_range(0, 1024)) - 16'd512;
            o[i] = ($urandom_range(0, 1) == 1) ? 32'($urandom())
                                                : 32'($urandom_range(0, 32'h00ff_ffff));
        end
        load_xform(q[0], q[1], q[2], q[3], {s[2], s[1], s[0]}, o[0], o[1], o[2]);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // reset transform is the identity
        send_point(KIND_POINT, 32'h0, 32'h0, 32'h0);
        send_point(KIND_DIR,   32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_point(KIND_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_point(KIND_DIR,   32'hffff_ffff, 32'h0000_0001, 32'h0);
        drain();

        // extreme, non-unit quaternion (-2.0 parts), extreme scale and offsets
        load_xform(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                   {16'h8000, 16'h7fff, 16'h0001},
                   32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_point(KIND_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(KIND_DIR,   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(KIND_POINT, 32'h0, 32'h0, 32'h0);
        send_point(KIND_POINT, 32'h1, 32'h1, 32'h1);
        send_point(KIND_DIR,   32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
        drain();

        // 90 degrees about z with uneven scale
        load_xform(16'd11585, 16'h0, 16'h0, 16'd11585,
                   {16'h0100, 16'h0080, 16'h0200},
                   32'h0001_0000, 32'hffff_0000, 32'h0);
        send_point(KIND_POINT, 32'h0001_0000, 32'h0, 32'h0);
        send_point(KIND_DIR,   32'h0, 32'h0001_0000, 32'h0);
        send_point(KIND_POINT, 32'hffff_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(KIND_DIR,   $urandom(), $urandom(), $urandom());
        drain();

        // offset pushes past the low limit
        load_xform(16'h4000, 16'h0, 16'h0, 16'h0,
                   {16'h0000, 16'h0000, 16'h0100},
                   32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_point(KIND_POINT, 32'h8000_0000, 32'h0, 32'h0);
        send_point(KIND_DIR,   32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(KIND_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            random_xform(ph % 4);
            steady = (ph == 2);
            if (ph == 1 || ph == 5)
                choke_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_point(logic'($urandom_range(0, 1)),
                           pick_coord(), pick_coord(), pick_coord());
            drain();
            steady = 1'b0;
        end

        repeat (NSTG + 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
